FILE: rtl/assert_macros.svh
// Assertion macros of the base64 stream decoder RTL, included by b64d_core.
// Depends on nothing; simulation builds see the checks, synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every rising clock edge outside reset.
`define B64D_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Checks that an expression is never true at a rising clock edge outside reset.
`define B64D_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`else

`define B64D_ASSERT(lbl, clk, rstn, prop)
`define B64D_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

FILE: rtl/b64d_pkg.sv
// Package of the base64 stream decoder: item types, phase encoding,
// alphabet constants and the character-to-sextet lookup. Depends on nothing.
package b64d_pkg;

  localparam int CountWidth  = 16;
  localparam int CharWidth   = 8;
  localparam int ByteWidth   = 8;
  localparam int SextetWidth = 6;
  localparam int PendWidth   = 3;
  localparam int AccWidth    = 12;

  localparam logic [CharWidth-1:0] CharUpperA = 8'h41;
  localparam logic [CharWidth-1:0] CharUpperZ = 8'h5A;
  localparam logic [CharWidth-1:0] CharLowerA = 8'h61;
  localparam logic [CharWidth-1:0] CharLowerZ = 8'h7A;
  localparam logic [CharWidth-1:0] CharDigit0 = 8'h30;
  localparam logic [CharWidth-1:0] CharDigit9 = 8'h39;
  localparam logic [CharWidth-1:0] CharPlus   = 8'h2B;
  localparam logic [CharWidth-1:0] CharSlash  = 8'h2F;
  localparam logic [CharWidth-1:0] CharPad    = 8'h3D;

  localparam logic [SextetWidth-1:0] LowerBase = 6'd26;
  localparam logic [SextetWidth-1:0] DigitBase = 6'd52;
  localparam logic [SextetWidth-1:0] PlusCode  = 6'd62;
  localparam logic [SextetWidth-1:0] SlashCode = 6'd63;

  localparam logic [PendWidth:0]   BitsPerChar = 4'd6;
  localparam logic [PendWidth:0]   BitsPerByte = 4'd8;
  localparam logic [PendWidth-1:0] BitsPerPad  = 3'd2;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_DATA = 4'b0010,
    PH_PAD  = 4'b0100,
    PH_DONE = 4'b1000
  } phase_e;

  typedef struct packed {
    logic                  first;
    logic [CountWidth-1:0] byte_count;
    logic [CharWidth-1:0]  char_code;
    logic                  last;
  } in_item_t;

  typedef struct packed {
    logic [ByteWidth-1:0] data_byte;
    logic                 byte_valid;
    logic                 done_res;
    logic                 failed;
  } out_item_t;

  // Bit 6 of the result flags a character outside the alphabet.
  function automatic logic [SextetWidth:0] sextet_of(logic [CharWidth-1:0] c);
    logic [SextetWidth:0] v;
    v = {1'b1, {SextetWidth{1'b0}}};
    if (c >= CharUpperA && c <= CharUpperZ) begin
      v = {1'b0, SextetWidth'(c - CharUpperA)};
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      v = {1'b0, SextetWidth'(c - CharLowerA) + LowerBase};
    end else if (c >= CharDigit0 && c <= CharDigit9) begin
      v = {1'b0, SextetWidth'(c - CharDigit0) + DigitBase};
    end else if (c == CharPlus) begin
      v = {1'b0, PlusCode};
    end else if (c == CharSlash) begin
      v = {1'b0, SlashCode};
    end
    return v;
  endfunction

endpackage

FILE: rtl/b64d_in_if.sv
// Input channel of the base64 stream decoder: valid/ready and one character item.
// Depends on b64d_pkg for the field widths.
interface b64d_in_if;
  logic                            valid;
  logic                            ready;
  logic                            first;
  logic [b64d_pkg::CountWidth-1:0] byte_count;
  logic [b64d_pkg::CharWidth-1:0]  char_code;
  logic                            last;

  modport source (output valid, first, byte_count, char_code, last, input ready);
  modport sink   (input valid, first, byte_count, char_code, last, output ready);
endinterface

FILE: rtl/b64d_out_if.sv
// Output channel of the base64 stream decoder: valid/ready and one result item.
// Depends on b64d_pkg for the field widths.
interface b64d_out_if;
  logic                           valid;
  logic                           ready;
  logic [b64d_pkg::ByteWidth-1:0] data_byte;
  logic                           byte_valid;
  logic                           done_res;
  logic                           failed;

  modport source (output valid, data_byte, byte_valid, done_res, failed, input ready);
  modport sink   (input valid, data_byte, byte_valid, done_res, failed, output ready);
endinterface

FILE: rtl/b64d_core.sv
// Input register, message state and the per-character decode logic.
// Depends on b64d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module b64d_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  b64d_pkg::in_item_t   in_item_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output b64d_pkg::out_item_t  res_item_o
);
  import b64d_pkg::*;

  logic                  in_valid_q, in_valid_d;
  in_item_t              item_q;
  logic                  fire;

  phase_e                phase_q, phase_d, ph_c;
  logic [PendWidth-1:0]  bits_q, bits_d, bits_c;
  logic [AccWidth-1:0]   acc_q, acc_d, acc_c, acc_new;
  logic [CountWidth-1:0] left_q, left_d, left_c;
  logic                  fail_q, fail_d, fail_c;

  logic [SextetWidth:0]  sext;
  logic [PendWidth:0]    sum;
  logic [PendWidth-1:0]  shamt;
  logic                  zero_cnt;
  logic [ByteWidth-1:0]  byte_d;
  logic                  byte_valid_d;

  assign fire        = in_valid_q && res_ready_i;
  assign in_ready_o  = !in_valid_q || res_ready_i;
  assign res_valid_o = in_valid_q;
  assign in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  always_comb begin
    sext     = sextet_of(item_q.char_code);
    zero_cnt = item_q.first && (item_q.byte_count == '0);

    ph_c   = phase_q;
    bits_c = bits_q;
    acc_c  = acc_q;
    left_c = left_q;
    fail_c = fail_q;
    if (item_q.first) begin
      bits_c = '0;
      acc_c  = '0;
      fail_c = 1'b0;
      left_c = item_q.byte_count;
      ph_c   = zero_cnt ? PH_DONE : PH_DATA;
    end

    acc_new = {acc_c[AccWidth-SextetWidth-1:0], sext[SextetWidth-1:0]};
    sum     = {1'b0, bits_c} + BitsPerChar;
    shamt   = PendWidth'(sum - BitsPerByte);

    phase_d      = ph_c;
    bits_d       = bits_c;
    acc_d        = acc_c;
    left_d       = left_c;
    fail_d       = fail_c;
    byte_d       = '0;
    byte_valid_d = 1'b0;

    if (!zero_cnt) begin
      case (ph_c)
        PH_DATA: begin
          if (sext[SextetWidth]) begin
            fail_d  = 1'b1;
            phase_d = PH_DONE;
          end else begin
            acc_d = acc_new;
            if (sum >= BitsPerByte) begin
              byte_d       = ByteWidth'(acc_new >> shamt);
              byte_valid_d = 1'b1;
              bits_d       = shamt;
              left_d       = left_c - CountWidth'(1);
            end else begin
              bits_d = sum[PendWidth-1:0];
            end
            if (left_d == '0) begin
              phase_d = (bits_d != '0 && !item_q.last) ? PH_PAD : PH_DONE;
            end else if (item_q.last) begin
              fail_d  = 1'b1;
              phase_d = PH_DONE;
            end
          end
        end
        PH_PAD: begin
          if (item_q.char_code != CharPad) begin
            fail_d = 1'b1;
          end
          bits_d = (bits_c >= BitsPerPad) ? bits_c - BitsPerPad : '0;
          if (bits_d == '0 || item_q.last) begin
            phase_d = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    res_item_o.data_byte  = byte_d;
    res_item_o.byte_valid = byte_valid_d;
    res_item_o.done_res   = (phase_d == PH_DONE);
    res_item_o.failed     = fail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bits_q  <= '0;
      acc_q   <= '0;
      left_q  <= '0;
      fail_q  <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d;
      bits_q  <= bits_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      fail_q  <= fail_d;
    end
  end

  `B64D_ASSERT(a_byte_from_data, clk_i, rst_ni, fire && res_item_o.byte_valid |-> phase_q == PH_DATA || item_q.first)
  `B64D_ASSERT(a_idle_holds, clk_i, rst_ni, fire && phase_q == PH_IDLE && !item_q.first |=> phase_q == PH_IDLE)
  `B64D_ASSERT(a_pad_has_bits, clk_i, rst_ni, phase_q == PH_PAD |-> bits_q != '0)
  `B64D_ASSERT(a_fail_sticky, clk_i, rst_ni, fire && fail_q && !item_q.first |-> res_item_o.failed)
  `B64D_ASSERT_NEVER(a_odd_bits, clk_i, rst_ni, bits_q[0])

endmodule

FILE: rtl/b64d_out_reg.sv
// Result register between the decode logic and the output channel.
// Depends on b64d_pkg.
module b64d_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  output logic                 res_ready_o,
  input  b64d_pkg::out_item_t  res_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output b64d_pkg::out_item_t  out_item_o
);
  import b64d_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign valid_d     = res_ready_o ? res_valid_i : valid_q;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      item_q <= res_item_i;
    end
  end

endmodule

FILE: rtl/base64_stream_decoder.sv
// Base64 stream decoder: one character per transaction in, one result per transaction out.
// The block sustains one transaction per clock cycle while the output is ready; each
// character passes an input register, then the decode and message-state update run
// combinationally into a result register, which offers the result on the output.
// The state update (accumulator, pending bit count and remaining byte count) is what
// sets that rate. When the output stalls, both registers fill and the input is held off
// until the result register drains.
// Depends on b64d_pkg, b64d_in_if, b64d_out_if, b64d_core and b64d_out_reg.
module base64_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64d_in_if.sink     in_i,
  b64d_out_if.source  out_o
);
  import b64d_pkg::*;

  in_item_t  in_item;
  out_item_t res_item;
  out_item_t out_item;
  logic      res_valid;
  logic      res_ready;
  logic      out_valid;

  assign in_item.first      = in_i.first;
  assign in_item.byte_count = in_i.byte_count;
  assign in_item.char_code  = in_i.char_code;
  assign in_item.last       = in_i.last;

  b64d_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_item_i   (in_item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_item_o  (res_item)
  );

  b64d_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_item_i  (res_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_item)
  );

  assign out_o.valid      = out_valid;
  assign out_o.data_byte  = out_item.data_byte;
  assign out_o.byte_valid = out_item.byte_valid;
  assign out_o.done_res   = out_item.done_res;
  assign out_o.failed     = out_item.failed;

endmodule

FILE: test/b64d_decode_check.sv
// Watches both channels of the base64 stream decoder, predicts each result from the
// accepted characters and compares it field by field. Depends on b64d_pkg and the
// b64d_in_if / b64d_out_if channel interfaces.
module b64d_decode_check
  import b64d_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  b64d_in_if   in_i,
  b64d_out_if  res_i,
  output int   mismatches_o,
  output int   pending_o
);

  phase_e                msg_phase   = PH_IDLE;
  logic [PendWidth-1:0]  pend_bits   = '0;
  logic [AccWidth-1:0]   acc_bits    = '0;
  logic [CountWidth-1:0] bytes_to_go = '0;
  logic                  fail_seen   = 1'b0;
  out_item_t             decoded_q[$];
  int                    mismatch_count = 0;

  function automatic out_item_t decode_char(input in_item_t it);
    out_item_t           r;
    logic [SextetWidth:0] sextet;
    logic [PendWidth:0]   nbits;
    r = '0;
    if (it.first) begin
      pend_bits   = '0;
      acc_bits    = '0;
      fail_seen   = 1'b0;
      bytes_to_go = it.byte_count;
      msg_phase   = (it.byte_count == '0) ? PH_DONE : PH_DATA;
    end
    if (!(it.first && it.byte_count == '0)) begin
      if (msg_phase == PH_DATA) begin
        sextet = {1'b1, {SextetWidth{1'b0}}};
        if (it.char_code >= CharUpperA && it.char_code <= CharUpperZ) begin
          sextet = {1'b0, SextetWidth'(it.char_code - CharUpperA)};
        end else if (it.char_code >= CharLowerA && it.char_code <= CharLowerZ) begin
          sextet = {1'b0, LowerBase + SextetWidth'(it.char_code - CharLowerA)};
        end else if (it.char_code >= CharDigit0 && it.char_code <= CharDigit9) begin
          sextet = {1'b0, DigitBase + SextetWidth'(it.char_code - CharDigit0)};
        end else if (it.char_code == CharPlus) begin
          sextet = {1'b0, PlusCode};
        end else if (it.char_code == CharSlash) begin
          sextet = {1'b0, SlashCode};
        end
        if (sextet[SextetWidth]) begin
          fail_seen = 1'b1;
          msg_phase = PH_DONE;
        end else begin
          acc_bits = {acc_bits[AccWidth-SextetWidth-1:0], sextet[SextetWidth-1:0]};
          nbits    = {1'b0, pend_bits} + BitsPerChar;
          if (nbits >= BitsPerByte) begin
            nbits        = nbits - BitsPerByte;
            r.data_byte  = ByteWidth'(acc_bits >> nbits);
            r.byte_valid = 1'b1;
            bytes_to_go  = bytes_to_go - 1'b1;
          end
          pend_bits = nbits[PendWidth-1:0];
          if (bytes_to_go == '0) begin
            msg_phase = (pend_bits != '0 && !it.last) ? PH_PAD : PH_DONE;
          end else if (it.last) begin
            fail_seen = 1'b1;
            msg_phase = PH_DONE;
          end
        end
      end else if (msg_phase == PH_PAD) begin
        if (it.char_code != CharPad) begin
          fail_seen = 1'b1;
        end
        pend_bits = (pend_bits >= BitsPerPad) ? pend_bits - BitsPerPad : '0;
        if (pend_bits == '0 || it.last) begin
          msg_phase = PH_DONE;
        end
      end
    end
    r.done_res = (msg_phase == PH_DONE);
    r.failed   = fail_seen;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    in_item_t  taken;
    if (!rst_ni) begin
      msg_phase   = PH_IDLE;
      pend_bits   = '0;
      acc_bits    = '0;
      bytes_to_go = '0;
      fail_seen   = 1'b0;
      decoded_q.delete();
      pending_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (decoded_q.size() == 0) begin
          $error("result transaction arrived with no character waiting for it");
          mismatch_count++;
        end else begin
          want = decoded_q[0];
          decoded_q.delete(0);
          if (res_i.data_byte !== want.data_byte) begin
            $error("data_byte: expected %0h, actual %0h", want.data_byte, res_i.data_byte);
            mismatch_count++;
          end
          if (res_i.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, actual %0b", want.byte_valid, res_i.byte_valid);
            mismatch_count++;
          end
          if (res_i.done_res !== want.done_res) begin
            $error("done_res: expected %0b, actual %0b", want.done_res, res_i.done_res);
            mismatch_count++;
          end
          if (res_i.failed !== want.failed) begin
            $error("failed: expected %0b, actual %0b", want.failed, res_i.failed);
            mismatch_count++;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        taken.first      = in_i.first;
        taken.byte_count = in_i.byte_count;
        taken.char_code  = in_i.char_code;
        taken.last       = in_i.last;
        decoded_q.push_back(decode_char(taken));
      end
      pending_o <= decoded_q.size();
    end
    mismatches_o <= mismatch_count;
  end

endmodule

FILE: test/tb_base64_stream_decoder.sv
// Top of the base64 stream decoder testbench: clock, reset, character stimulus with
// bursty sending, result-side stalls and the verdict. Depends on b64d_pkg, the channel
// interfaces, base64_stream_decoder and b64d_decode_check.
module tb_base64_stream_decoder;
  import b64d_pkg::*;

  localparam int RandomItems  = 1000;
  localparam int LongHold     = 300;
  localparam int QuietLimit   = 2000;
  localparam int SettleCycles = 8;
  localparam int HoldMessage  = 20;
  localparam int HoldSpan     = 10;
  localparam int DrainEvery   = 25;

  typedef enum int {ALWAYS_READY, COIN_FLIP, MOSTLY_READY, MASK_PATTERN} stall_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   pending;
  int   mismatches;
  int   items_sent   = 0;
  int   burst_left   = 0;
  int   quiet_cycles = 0;
  bit   gaps_on      = 1'b1;
  bit   hold_req     = 1'b0;

  b64d_in_if  in_ch();
  b64d_out_if out_ch();

  base64_stream_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  b64d_decode_check decode_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .res_i        (out_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("base64_stream_decoder test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [CharWidth-1:0] b64_char(input logic [SextetWidth-1:0] v);
    if (v < LowerBase) return CharUpperA + CharWidth'(v);
    if (v < DigitBase) return CharLowerA + CharWidth'(v - LowerBase);
    if (v < PlusCode) return CharDigit0 + CharWidth'(v - DigitBase);
    return (v == PlusCode) ? CharPlus : CharSlash;
  endfunction

  task automatic send_item(input logic f, input logic [CountWidth-1:0] cnt,
                           input logic [CharWidth-1:0] c, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.first      <= f;
    in_ch.byte_count <= cnt;
    in_ch.char_code  <= c;
    in_ch.last       <= l;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_chars(input logic [CountWidth-1:0] cnt, input string s,
                            input logic end_last);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_item(i == 0, cnt, s[i], end_last && (i == s.len() - 1));
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic send_message();
    in_item_t              items[$];
    logic [CharWidth-1:0]  chars[$];
    in_item_t              it;
    logic [CountWidth-1:0] cnt;
    int n, i, k, pick, nbits, bitbuf, pads;
    nbits  = 0;
    bitbuf = 0;
    pads   = 0;
    pick   = $urandom_range(0, 99);
    if (pick < 3) begin
      n = 0;
      chars.push_back(CharWidth'($urandom));
    end else if (pick < 8) begin
      n = $urandom_range(256, 65535);
      repeat ($urandom_range(1, 4)) chars.push_back(b64_char(SextetWidth'($urandom)));
    end else begin
      n = (pick < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      for (i = 0; i < n; i++) begin
        bitbuf = (bitbuf << 8) | $urandom_range(0, 255);
        nbits += 8;
        while (nbits >= 6) begin
          nbits -= 6;
          chars.push_back(b64_char(SextetWidth'(bitbuf >> nbits)));
        end
        bitbuf &= (1 << nbits) - 1;
      end
      if (nbits > 0) begin
        chars.push_back(b64_char(SextetWidth'(bitbuf << (6 - nbits))));
        pads = (6 - nbits) / 2;
      end
    end
    cnt = CountWidth'(n);
    for (i = 0; i < chars.size(); i++) begin
      it.first      = (i == 0);
      it.byte_count = (i == 0) ? cnt : CountWidth'($urandom);
      it.char_code  = chars[i];
      it.last       = 1'b0;
      items.push_back(it);
    end
    repeat (pads) begin
      it.first      = 1'b0;
      it.byte_count = CountWidth'($urandom);
      it.char_code  = CharPad;
      it.last       = 1'b0;
      items.push_back(it);
    end
    case ($urandom_range(0, 9))
      0: begin
        k = $urandom_range(0, items.size() - 1);
        items[k].char_code = CharWidth'($urandom);
      end
      1: begin
        if (pads > 0) begin
          k = items.size() - 1 - $urandom_range(0, pads - 1);
          items[k].char_code = CharWidth'($urandom);
        end
      end
      2: begin
        if (items.size() > 1) begin
          k = $urandom_range(0, items.size() - 2);
          items = items[0:k];
        end
      end
      3: begin
        if (n > 1 && $urandom_range(0, 1)) begin
          items[0].byte_count = cnt - 1'b1;
        end else begin
          items[0].byte_count = cnt + CountWidth'($urandom_range(1, 3));
        end
      end
      default: ;
    endcase
    if ($urandom_range(0, 1)) begin
      items[items.size() - 1].last = 1'b1;
    end
    repeat ($urandom_range(0, 2)) begin
      it.first      = 1'b0;
      it.byte_count = CountWidth'($urandom);
      it.char_code  = CharWidth'($urandom);
      it.last       = 1'($urandom);
      items.push_back(it);
    end
    foreach (items[j]) begin
      send_item(items[j].first, items[j].byte_count, items[j].char_code, items[j].last);
    end
  endtask

  initial begin
    stall_mode_e mode;
    int          span;
    int          cyc;
    logic [7:0]  mask;
    bit          hold_done;
    hold_done = 1'b0;
    cyc       = 0;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(32, 200);
      mask = 8'($urandom) | 8'h01;
      repeat (span) begin
        if (hold_req && !hold_done) begin
          hold_done = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (LongHold) @(posedge clk_i);
        end
        case (mode)
          ALWAYS_READY: out_ch.ready <= 1'b1;
          COIN_FLIP:    out_ch.ready <= 1'($urandom);
          MOSTLY_READY: out_ch.ready <= ($urandom_range(0, 7) != 0);
          default:      out_ch.ready <= mask[cyc % 8];
        endcase
        cyc++;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int msg_idx;
    int directed_end;
    in_ch.valid      <= 1'b0;
    in_ch.first      <= 1'b0;
    in_ch.byte_count <= '0;
    in_ch.char_code  <= '0;
    in_ch.last       <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(1'b0, 16'hFFFF, CharUpperA, 1'b1);
    send_chars(16'd0, "Q", 1'b0);
    send_item(1'b0, 16'h0000, 8'h80, 1'b0);
    send_chars(16'd1, "/w==", 1'b0);
    send_chars(16'd3, "+Aa9", 1'b1);
    send_chars(16'd2, "A*", 1'b0);
    send_chars(16'hFFFF, "z0", 1'b1);
    send_chars(16'd1, "AAx=", 1'b0);
    send_chars(16'd1, "AA", 1'b1);
    send_chars(16'd2, "AB", 1'b0);
    send_chars(16'd1, "AA=", 1'b1);
    directed_end = items_sent;

    msg_idx = 0;
    while (items_sent < directed_end + RandomItems) begin
      if (msg_idx == HoldMessage) begin
        hold_req <= 1'b1;
      end
      if (msg_idx >= HoldMessage && msg_idx < HoldMessage + HoldSpan) begin
        gaps_on = 1'b0;
      end else begin
        gaps_on = ($urandom_range(0, 4) != 0);
      end
      if (msg_idx % DrainEvery == DrainEvery - 1) begin
        wait_drained();
      end
      send_message();
      msg_idx++;
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("base64_stream_decoder test passed");
    end else begin
      $display("base64_stream_decoder test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/b64d_pkg.sv
rtl/b64d_in_if.sv
rtl/b64d_out_if.sv
rtl/b64d_core.sv
rtl/b64d_out_reg.sv
rtl/base64_stream_decoder.sv
test/b64d_decode_check.sv
test/tb_base64_stream_decoder.sv
